/* src/rti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the radix trie index
// Field widths, status codes, action codes and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rti_pkg;

  // Fixed geometry: one key byte selects one of 256 entries in a layer
  localparam int RADIX  = 256;
  localparam int BYTE_W = 8;

  // Payload widths
  localparam int KEY_W    = 64;
  localparam int LEN_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int KIDX_W   = 3;   // byte index into the 64-bit key

  // Parameter defaults
  localparam int POOL_LAYERS_DEF = 64;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int VALUE_BITS_DEF  = 32;

  // Request actions
  localparam logic ACT_FIND = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INVALID   = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NO_MEMORY = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    clr_step;    // write zero at the clear pointer, advance it
    logic    load;        // capture the request
    logic    rd;          // read the entry at the current layer and key byte
    logic    adv;         // follow the child link read back
    logic    alloc;       // link a fresh layer into the current entry and follow it
    logic    put_val;     // store the request value in the current entry
    logic    res_load;    // load the result register
    logic    res_found;   // result carries the value read back
    status_e res_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;      // clear pointer at the last entry
    logic req_bad;       // request on the input port is invalid
    logic is_add;        // captured request is an add
    logic at_last;       // walk is at the final key byte
    logic child_zero;    // entry read back has no child
    logic ent_val_zero;  // entry read back holds no value
    logic pool_full;     // no layer left to hand out
    logic out_free;      // result register can take a new result
  } sts_t;

endpackage
`default_nettype wire

/* src/rti_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_if: request and response channels of the radix trie index
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface rti_req_if;
  import rti_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [KEY_W-1:0]   key;
  logic [LEN_W-1:0]   key_length;
  logic [VALUE_W-1:0] value;

  modport source (output valid, action, key, key_length, value, input ready);
  modport sink   (input valid, action, key, key_length, value, output ready);
endinterface

interface rti_rsp_if;
  import rti_pkg::*;

  logic               valid;
  logic               ready;
  status_e            status;
  logic [VALUE_W-1:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

/* src/rti_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_ctrl: sequencer of the radix trie index
// Runs the clearing pass after reset, then walks each valid request one key
// byte at a time: a read state, then an evaluate state that follows,
// allocates, stores or finishes.
// ----------------------------------------------------------------------------
module rti_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output rti_pkg::cmd_t      cmd_o,
  input  wire rti_pkg::sts_t sts_i
);
  import rti_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  logic    found_q, found_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    found_d        = found_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.res_status = res_q;
    cmd_o.res_found  = found_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          found_d    = 1'b0;
          if (sts_i.req_bad) begin
            res_d   = ST_INVALID;
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_DONE;
        if (!sts_i.at_last) begin
          // inner layer: follow the link, or extend the path on add
          if (!sts_i.child_zero) begin
            cmd_o.adv = 1'b1;
            state_d   = S_READ;
          end else if (!sts_i.is_add) begin
            res_d = ST_NOT_FOUND;
          end else if (sts_i.pool_full) begin
            res_d = ST_NO_MEMORY;
          end else begin
            cmd_o.alloc = 1'b1;
            state_d     = S_READ;
          end
        end else if (!sts_i.is_add) begin
          // final byte of a find
          if (!sts_i.ent_val_zero) begin
            res_d   = ST_OK;
            found_d = 1'b1;
          end else begin
            res_d = ST_NOT_FOUND;
          end
        end else if (!sts_i.ent_val_zero) begin
          res_d = ST_EXISTS;
        end else begin
          cmd_o.put_val = 1'b1;
          res_d         = ST_OK;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= ST_OK;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      found_q <= found_d;
    end
  end

  // A value is only ever stored into an empty entry on add
  a_put_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.put_val |-> (sts_i.is_add && sts_i.ent_val_zero))
    else $error("value stored over an occupied entry");

  // No request is taken before the store is cleared
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("request taken during clearing pass");

  // A taken request goes to a walk or straight to its result
  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_READ || state_q == S_DONE))
    else $error("bad state after request transfer");

endmodule
`default_nettype wire

/* src/rti_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_dp: datapath of the radix trie index
// Layer memory, request registers, walk position, free-layer pointer,
// clear pointer and the result register.
// ----------------------------------------------------------------------------
module rti_dp #(
  parameter int POOL_LAYERS = rti_pkg::POOL_LAYERS_DEF,
  parameter int KEY_BYTES   = rti_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS  = rti_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          action_i,
  input  wire logic [rti_pkg::KEY_W-1:0]     key_i,
  input  wire logic [rti_pkg::LEN_W-1:0]     key_length_i,
  input  wire logic [rti_pkg::VALUE_W-1:0]   value_i,
  input  wire rti_pkg::cmd_t                 cmd_i,
  output rti_pkg::sts_t                      sts_o,
  output logic                               rsp_valid_o,
  input  wire logic                          rsp_ready_i,
  output rti_pkg::status_e                   rsp_status_o,
  output logic [rti_pkg::VALUE_W-1:0]        rsp_found_value_o
);
  import rti_pkg::*;

  localparam int LW     = $clog2(POOL_LAYERS);
  localparam int ADDR_W = LW + BYTE_W;
  localparam int DEPTH  = POOL_LAYERS * RADIX;
  localparam int SVW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int ENT_W  = LW + SVW;

  // Request registers
  logic              action_q;
  logic [KEY_W-1:0]  key_q;
  logic [LEN_W-1:0]  len_q;
  logic [SVW-1:0]    val_q;

  // Walk and pool state
  logic [LW-1:0]     layer_q;
  logic [KIDX_W-1:0] idx_q;
  logic [LW:0]       nf_q;
  logic [ADDR_W-1:0] clr_q;

  // Memory
  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  rdata_q;
  logic [ENT_W-1:0]  wdata;
  logic [ADDR_W-1:0] addr;
  logic              we;
  logic [BYTE_W-1:0] kbyte;
  logic [LW-1:0]     ent_child;
  logic [SVW-1:0]    ent_val;

  // Result register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [VALUE_W-1:0] out_found_q;

  assign kbyte     = key_q[{idx_q, 3'b000} +: BYTE_W];
  assign ent_child = rdata_q[ENT_W-1 -: LW];
  assign ent_val   = rdata_q[SVW-1:0];

  // Memory address and write data
  always_comb begin
    addr  = cmd_i.clr_step ? clr_q : {layer_q, kbyte};
    we    = cmd_i.clr_step | cmd_i.alloc | cmd_i.put_val;
    wdata = '0;
    if (cmd_i.alloc) begin
      wdata = {nf_q[LW-1:0], ent_val};
    end else if (cmd_i.put_val) begin
      wdata = {ent_child, val_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr];
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      key_q    <= key_i;
      len_q    <= key_length_i;
      val_q    <= value_i[SVW-1:0];
    end
  end

  // Walk position, free-layer pointer, clear pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_q <= '0;
      idx_q   <= '0;
      nf_q    <= (LW+1)'(1);
      clr_q   <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load) begin
        layer_q <= '0;
        idx_q   <= '0;
      end else if (cmd_i.adv) begin
        layer_q <= ent_child;
        idx_q   <= idx_q + 1'b1;
      end else if (cmd_i.alloc) begin
        layer_q <= nf_q[LW-1:0];
        idx_q   <= idx_q + 1'b1;
        nf_q    <= nf_q + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_found_q  <= cmd_i.res_found ? VALUE_W'(ent_val) : '0;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_status_q;
  assign rsp_found_value_o = out_found_q;

  // Status to the controller
  always_comb begin
    sts_o              = '0;
    sts_o.clr_last     = (clr_q == ADDR_W'(DEPTH - 1));
    sts_o.req_bad      = (key_length_i == '0) ||
                         (key_length_i > LEN_W'(KEY_BYTES)) ||
                         ((action_i == ACT_ADD) && (value_i[SVW-1:0] == '0));
    sts_o.is_add       = (action_q == ACT_ADD);
    sts_o.at_last      = ({1'b0, idx_q} == (len_q - 1'b1));
    sts_o.child_zero   = (ent_child == '0);
    sts_o.ent_val_zero = (ent_val == '0);
    sts_o.pool_full    = (nf_q >= (LW+1)'(POOL_LAYERS));
    sts_o.out_free     = !out_valid_q || rsp_ready_i;
  end

  // A result never overwrites one that is still waiting
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result register overwritten");

  // Each allocation hands out exactly the next layer
  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |=> (nf_q == $past(nf_q) + 1'b1))
    else $error("free-layer pointer did not advance");

  // Single port: a read cycle carries no write
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> !we)
    else $error("read and write in the same cycle");

endmodule
`default_nettype wire

/* src/radix_trie_index_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_trie_index_core: byte-wise radix-256 trie index
// Find and add of keys of up to KEY_BYTES bytes over a fixed pool of layers.
// ----------------------------------------------------------------------------
// After reset the block sweeps its layer memory clear, one entry per cycle,
// and takes no request until that is done. A request with a bad length or a
// zero add value goes straight to its result. The single memory port shapes
// the walk: every key byte goes through a read state and an evaluate state,
// and an add makes one combined walk that links fresh layers as it goes. One
// request is worked at a time; a new one is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module radix_trie_index_core #(
  parameter int POOL_LAYERS = rti_pkg::POOL_LAYERS_DEF,
  parameter int KEY_BYTES   = rti_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BITS  = rti_pkg::VALUE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rti_req_if.sink   req_i,
  rti_rsp_if.source rsp_o
);
  import rti_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;

  // Sequencer
  rti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Memory and registers
  rti_dp #(
    .POOL_LAYERS (POOL_LAYERS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .action_i          (req_i.action),
    .key_i             (req_i.key),
    .key_length_i      (req_i.key_length),
    .value_i           (req_i.value),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_found_value_o (rsp_o.found_value)
  );

endmodule
`default_nettype wire
